/* sv/dnsp_pkg.sv */
// Package for the DNS message field parser: section, field and status codes,
// and the beat types of the input and output channels. No dependencies.
package dnsp_pkg;

    localparam logic [2:0] SEC_HEADER   = 3'd0;
    localparam logic [2:0] SEC_QUESTION = 3'd1;
    localparam logic [2:0] SEC_TRAILING = 3'd5;

    localparam logic [3:0] K_ID         = 4'd0;
    localparam logic [3:0] K_LABEL_LEN  = 4'd6;
    localparam logic [3:0] K_LABEL_CHAR = 4'd7;
    localparam logic [3:0] K_POINTER    = 4'd8;
    localparam logic [3:0] K_NAME_END   = 4'd9;
    localparam logic [3:0] K_TYPE       = 4'd10;
    localparam logic [3:0] K_CLASS      = 4'd11;
    localparam logic [3:0] K_TTL        = 4'd12;
    localparam logic [3:0] K_RDLENGTH   = 4'd13;
    localparam logic [3:0] K_RDATA      = 4'd14;
    localparam logic [3:0] K_TRAILING   = 4'd15;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRUNC    = 3'd1;
    localparam logic [2:0] ST_TRAIL    = 3'd2;
    localparam logic [2:0] ST_LONG     = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;

    localparam logic [7:0] PTR_MASK    = 8'hc0;
    localparam int         HEADER_BYTES = 12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  section;
        logic [3:0]  field_kind;
        logic [15:0] record_index;
        logic        field_done;
        logic [31:0] field_value;
        logic [2:0]  status;
        logic        message_done;
    } t_out_beat;

endpackage

/* sv/dnsp_in_if.sv */
// Input channel: valid/ready handshake carrying one datagram byte a beat.
// Depends on dnsp_pkg.
interface dnsp_in_if import dnsp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/dnsp_out_if.sv */
// Output channel: valid/ready handshake carrying one classified byte a beat.
// Depends on dnsp_pkg.
interface dnsp_out_if import dnsp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/dnsp_front.sv */
// Front end: accepts datagram bytes and registers them into a two-entry queue.
// Depends on dnsp_pkg and dnsp_in_if.
module dnsp_front import dnsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dnsp_in_if.sink  in_ch,
    input  logic     i_pop,
    output logic     o_valid,
    output t_in_beat o_beat
);
    t_in_beat   r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       push;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign o_valid     = (r_cnt != 2'd0);
    assign o_beat      = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
        if (push) begin
            r_q[r_wr] <= in_ch.data;
        end
    end

    property p_no_overpop;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> r_cnt != 2'd0;
    endproperty
    a_no_overpop: assert property (p_no_overpop) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !in_ch.ready) else $error("ready while full");
endmodule

/* sv/dnsp_back.sv */
// Back end: per-byte parse state machine with a registered output stage.
// Depends on dnsp_pkg and dnsp_out_if.
module dnsp_back import dnsp_pkg::*; #(
    parameter int MAX_NAME_BYTES = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_beat,
    output logic      o_pop,
    dnsp_out_if.source out_ch
);
    logic [3:0]  r_hb, n_hb;
    logic [15:0] r_cnt [4];
    logic [15:0] n_cnt [4];
    logic [2:0]  r_sec, n_sec;
    logic [15:0] r_rec, n_rec;
    logic [3:0]  r_fld, n_fld;
    logic [15:0] r_left, n_left;
    logic [5:0]  r_lbl, n_lbl;
    logic [7:0]  r_nlen, n_nlen;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_st, n_st;
    logic        r_ov;
    t_out_beat   r_ob, ob;
    logic [31:0] acc_sh;
    logic [9:0]  nl;
    logic [15:0] rec_inc;
    logic        fin;
    logic [5:0]  len;

    assign o_pop        = i_valid && (!r_ov || out_ch.ready);
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_ob;

    always_comb begin
        n_hb = r_hb; n_cnt = r_cnt; n_sec = r_sec; n_rec = r_rec; n_fld = r_fld;
        n_left = r_left; n_lbl = r_lbl; n_nlen = r_nlen; n_acc = r_acc; n_st = r_st;
        fin = 1'b0;
        ob = '0;
        ob.section = r_sec;
        ob.record_index = r_rec;
        acc_sh = {r_acc[23:0], i_beat.data_byte};
        rec_inc = r_rec + 16'd1;
        len = i_beat.data_byte[5:0];
        nl = {2'b0, r_nlen} + {4'b0, len} + 10'd1;
        if (r_sec == SEC_HEADER) begin
            ob.field_kind = {1'b0, r_hb[3:1]};
            ob.record_index = '0;
            n_acc = acc_sh;
            if (r_hb[0]) begin
                ob.field_done = 1'b1;
                ob.field_value = {16'd0, acc_sh[15:0]};
                if (r_hb[3:1] >= 3'd2 && r_hb[3:1] <= 3'd5) begin
                    n_cnt[2'(r_hb[3:1] - 3'd2)] = acc_sh[15:0];
                end
                n_acc = '0;
            end
            n_hb = r_hb + 4'd1;
        end else if (r_sec >= SEC_TRAILING) begin
            ob.field_kind = K_TRAILING;
            ob.record_index = '0;
            if (n_st == ST_OK) n_st = ST_TRAIL;
        end else begin
            case (r_fld)
                K_LABEL_CHAR: begin
                    ob.field_kind = K_LABEL_CHAR;
                    if (r_lbl != '0) n_lbl = r_lbl - 6'd1;
                    if (n_lbl == '0) n_fld = K_LABEL_LEN;
                end
                K_POINTER: begin
                    ob.field_kind = K_POINTER;
                    ob.field_done = 1'b1;
                    ob.field_value = {16'd0, acc_sh[15:0]};
                    n_fld = K_TYPE; n_left = 16'd2; n_acc = '0;
                end
                K_TYPE, K_CLASS, K_TTL, K_RDLENGTH, K_RDATA: begin
                    ob.field_kind = r_fld;
                    n_acc = acc_sh;
                    if (r_left != '0) n_left = r_left - 16'd1;
                    if (n_left == '0) begin
                        ob.field_done = 1'b1;
                        ob.field_value = acc_sh;
                        n_acc = '0;
                        case (r_fld)
                            K_TYPE: begin n_fld = K_CLASS; n_left = 16'd2; end
                            K_CLASS: begin
                                if (r_sec == SEC_QUESTION) fin = 1'b1;
                                else begin n_fld = K_TTL; n_left = 16'd4; end
                            end
                            K_TTL: begin n_fld = K_RDLENGTH; n_left = 16'd2; end
                            K_RDLENGTH: begin
                                if (acc_sh[15:0] == '0) fin = 1'b1;
                                else begin
                                    n_fld = K_RDATA; n_left = acc_sh[15:0];
                                end
                            end
                            default: fin = 1'b1;
                        endcase
                    end
                end
                default: begin
                    if ((i_beat.data_byte & PTR_MASK) == PTR_MASK) begin
                        ob.field_kind = K_POINTER;
                        n_fld = K_POINTER;
                        n_acc = {24'd0, i_beat.data_byte};
                    end else begin
                        if (i_beat.data_byte[7:6] != 2'b00 && n_st == ST_OK)
                            n_st = ST_RESERVED;
                        if (len == '0) begin
                            ob.field_kind = K_NAME_END;
                            n_fld = K_TYPE; n_left = 16'd2; n_acc = '0;
                        end else begin
                            ob.field_kind = K_LABEL_LEN;
                            if (nl + 10'd1 > 10'(MAX_NAME_BYTES) && n_st == ST_OK)
                                n_st = ST_LONG;
                            n_nlen = (nl > 10'd255) ? 8'd255 : nl[7:0];
                            n_lbl = len;
                            n_fld = K_LABEL_CHAR;
                        end
                    end
                end
            endcase
        end
        // record end: next record; last one or header end: next section with records
        if (fin && rec_inc < r_cnt[2'(r_sec - 3'd1)]) begin
            n_rec = rec_inc;
            n_fld = K_LABEL_LEN; n_nlen = '0; n_lbl = '0;
        end else if (fin || (r_sec == SEC_HEADER && n_hb >= 4'(HEADER_BYTES))) begin
            n_rec = '0;
            n_fld = K_LABEL_LEN; n_nlen = '0; n_lbl = '0;
            if (r_sec < 3'd1 && n_cnt[0] != '0) n_sec = 3'd1;
            else if (r_sec < 3'd2 && n_cnt[1] != '0) n_sec = 3'd2;
            else if (r_sec < 3'd3 && n_cnt[2] != '0) n_sec = 3'd3;
            else if (r_sec < 3'd4 && n_cnt[3] != '0) n_sec = 3'd4;
            else begin
                n_sec = SEC_TRAILING;
                ob.message_done = 1'b1;
            end
        end
        if (i_beat.last_byte) begin
            if (n_sec != SEC_TRAILING && n_st == ST_OK) n_st = ST_TRUNC;
            ob.message_done = 1'b1;
        end
        ob.status = n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_beat.last_byte)) begin
            r_hb <= '0; r_cnt <= '{default: '0}; r_sec <= SEC_HEADER; r_rec <= '0;
            r_fld <= K_ID; r_left <= '0; r_lbl <= '0; r_nlen <= '0; r_acc <= '0;
            r_st <= ST_OK;
        end else if (o_pop) begin
            r_hb <= n_hb; r_cnt <= n_cnt; r_sec <= n_sec; r_rec <= n_rec;
            r_fld <= n_fld; r_left <= n_left; r_lbl <= n_lbl; r_nlen <= n_nlen;
            r_acc <= n_acc; r_st <= n_st;
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop) begin
            r_ov <= 1'b1;
        end else if (out_ch.ready) begin
            r_ov <= 1'b0;
        end
        if (o_pop) begin
            r_ob <= ob;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> $stable(r_ob)) else $error("result lost");
    a_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec <= SEC_TRAILING) else $error("bad section");
    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sec == SEC_HEADER) |-> r_hb < 4'(HEADER_BYTES)) else $error("header overrun");
endmodule

/* sv/dns_message_field_parser.sv */
// Top level of the DNS message field parser.
// Depends on dnsp_pkg, dnsp_in_if, dnsp_out_if, dnsp_front and dnsp_back.
//
// Usage: datagram bytes enter on i_in, one per beat, last_byte marking the
// final byte. Every byte gives exactly one beat on o_out: section, field kind,
// record index, completed big-endian field value, sticky status and
// message_done. Header counts steer the walk over questions and records.
// An input beat passes through the queue and then the result register on its
// way to o_out. Throughput: one byte per cycle while the receiver is ready.
// When the receiver stalls, the result register holds and the queue takes
// one more beat, then in ready drops until the stall clears and the queue
// drains below full. After the last_byte beat the parse state returns to
// reset, so the next byte opens a new datagram. Reset empties the queue and
// output stage and clears all parse state.
module dns_message_field_parser import dnsp_pkg::*; #(
    parameter int MAX_NAME_BYTES = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dnsp_in_if.sink    i_in,
    dnsp_out_if.source o_out
);
    logic     q_valid, pop;
    t_in_beat q_beat;

    dnsp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(i_in),
        .i_pop(pop), .o_valid(q_valid), .o_beat(q_beat)
    );

    dnsp_back #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_beat(q_beat),
        .o_pop(pop), .out_ch(o_out)
    );
endmodule

/* sim/dns_message_field_parser_tb.sv */
// Testbench for dns_message_field_parser: drives DNS datagram bytes and checks
// every classified beat against a cycle-free predictor of the parse walk.
// Depends on dnsp_pkg, dnsp_in_if, dnsp_out_if and the parser RTL.
module dns_message_field_parser_tb;
    import dnsp_pkg::*;

    logic i_clk;
    logic i_rst_n;
    dnsp_in_if  in_ch ();
    dnsp_out_if out_ch ();

    dns_message_field_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // predictor state
    logic [3:0]  p_hdr_cnt;
    logic [15:0] p_counts [4];
    logic [2:0]  p_sec;
    logic [15:0] p_rec;
    logic [3:0]  p_field;
    logic [15:0] p_left;
    logic [5:0]  p_label_left;
    logic [7:0]  p_name_len;
    logic [31:0] p_acc;
    logic [2:0]  p_status;
    logic        p_finished;

    t_in_beat  byte_q [$];
    t_out_beat parsed_q [$];
    int        n_fail;
    bit        hold_send;
    int        gap_left;
    int        burst_left;
    int        stall_phase;

    function automatic void parse_reset();
        p_hdr_cnt = '0;
        for (int i = 0; i < 4; i++) p_counts[i] = '0;
        p_sec = SEC_HEADER;
        p_rec = '0;
        p_field = K_ID;
        p_left = '0;
        p_label_left = '0;
        p_name_len = '0;
        p_acc = '0;
        p_status = ST_OK;
        p_finished = 1'b0;
    endfunction

    function automatic void raise(logic [2:0] code);
        if (p_status == ST_OK) p_status = code;
    endfunction

    function automatic void open_name();
        p_field = K_LABEL_LEN;
        p_name_len = '0;
        p_label_left = '0;
    endfunction

    function automatic void open_fixed(logic [3:0] kind, logic [15:0] len);
        p_field = kind;
        p_left = len;
        p_acc = '0;
    endfunction

    function automatic void next_section();
        for (int s = int'(p_sec) + 1; s <= 4; s++) begin
            if (p_counts[s-1] != 0) begin
                p_sec = 3'(s);
                p_rec = '0;
                open_name();
                return;
            end
        end
        p_sec = SEC_TRAILING;
        p_rec = '0;
        p_finished = 1'b1;
    endfunction

    function automatic void close_record();
        p_rec = p_rec + 16'd1;
        if (p_rec >= p_counts[(p_sec - 3'd1) & 3'd3]) next_section();
        else open_name();
    endfunction

    function automatic t_out_beat parse_byte(t_in_beat ib);
        t_out_beat r;
        logic [7:0]  b;
        logic [2:0]  sec;
        logic [15:0] rec;
        logic [3:0]  kind;
        logic [31:0] value;
        logic        done;
        logic        mdone;
        int          n;
        b = ib.data_byte;
        sec = p_sec;
        rec = p_rec;
        kind = K_ID;
        value = '0;
        done = 1'b0;
        p_finished = 1'b0;
        if (sec == SEC_HEADER) begin
            kind = 4'(p_hdr_cnt >> 1);
            p_acc = {p_acc[23:0], b};
            if (p_hdr_cnt[0]) begin
                done = 1'b1;
                value = {16'd0, p_acc[15:0]};
                if (kind >= 4'd2 && kind <= 4'd5) p_counts[kind-2] = p_acc[15:0];
                p_acc = '0;
            end
            p_hdr_cnt = p_hdr_cnt + 4'd1;
            if (p_hdr_cnt >= HEADER_BYTES) next_section();
        end else if (sec >= SEC_TRAILING) begin
            kind = K_TRAILING;
            rec = '0;
            raise(ST_TRAIL);
        end else if (p_field == K_LABEL_CHAR) begin
            kind = K_LABEL_CHAR;
            if (p_label_left > 0) p_label_left--;
            if (p_label_left == 0) p_field = K_LABEL_LEN;
        end else if (p_field == K_POINTER) begin
            kind = K_POINTER;
            done = 1'b1;
            value = {16'd0, p_acc[7:0], b};
            open_fixed(K_TYPE, 16'd2);
        end else if (p_field >= K_TYPE && p_field <= K_RDATA) begin
            kind = p_field;
            p_acc = {p_acc[23:0], b};
            if (p_left > 0) p_left--;
            if (p_left == 0) begin
                done = 1'b1;
                value = p_acc;
                case (kind)
                    K_TYPE:  open_fixed(K_CLASS, 16'd2);
                    K_CLASS: begin
                        if (sec == SEC_QUESTION) close_record();
                        else open_fixed(K_TTL, 16'd4);
                    end
                    K_TTL:   open_fixed(K_RDLENGTH, 16'd2);
                    K_RDLENGTH: begin
                        if (p_acc[15:0] == 0) close_record();
                        else open_fixed(K_RDATA, p_acc[15:0]);
                    end
                    default: close_record();
                endcase
            end
        end else if ((b & PTR_MASK) == PTR_MASK) begin
            kind = K_POINTER;
            p_field = K_POINTER;
            p_acc = {24'd0, b};
        end else begin
            if ((b & PTR_MASK) != 0) raise(ST_RESERVED);
            if (b[5:0] == 0) begin
                kind = K_NAME_END;
                open_fixed(K_TYPE, 16'd2);
            end else begin
                n = int'(p_name_len) + int'(b[5:0]) + 1;
                kind = K_LABEL_LEN;
                if (n + 1 > 255) raise(ST_LONG);
                p_name_len = n > 255 ? 8'd255 : 8'(n);
                p_label_left = b[5:0];
                p_field = K_LABEL_CHAR;
            end
        end
        mdone = p_finished;
        if (ib.last_byte) begin
            if (p_sec != SEC_TRAILING) raise(ST_TRUNC);
            mdone = 1'b1;
        end
        r.section = sec;
        r.field_kind = kind;
        r.record_index = (sec == SEC_HEADER || sec >= SEC_TRAILING) ? 16'd0 : rec;
        r.field_done = done;
        r.field_value = done ? value : 32'd0;
        r.status = p_status;
        r.message_done = mdone;
        if (ib.last_byte) parse_reset();
        return r;
    endfunction

    // datagram builders
    t_in_beat gram [$];

    task automatic put(logic [7:0] b);
        t_in_beat x;
        x.data_byte = b;
        x.last_byte = 1'b0;
        gram.push_back(x);
    endtask

    task automatic put16(logic [15:0] v);
        put(v[15:8]);
        put(v[7:0]);
    endtask

    task automatic put_name(int labels, bit with_ptr, bit reserved);
        int len;
        for (int i = 0; i < labels; i++) begin
            len = $urandom_range(1, 10);
            put(reserved && i == 0 ? 8'(8'h40 | len) : 8'(len));
            for (int j = 0; j < len; j++) put(8'($urandom));
        end
        if (with_ptr) put16(16'($urandom) | 16'hc000);
        else put(8'h00);
    endtask

    task automatic put_long_name();
        for (int i = 0; i < 5; i++) begin
            put(8'd63);
            for (int j = 0; j < 63; j++) put(8'($urandom));
        end
        put(8'h00);
    endtask

    // counts: qd, an, ns, ar; rd is rdlength upper bound
    task automatic build_gram(int qd, int an, int ns, int ar, int rd, int trail, int cut);
        int rl;
        gram.delete();
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'(qd)); put16(16'(an)); put16(16'(ns)); put16(16'(ar));
        for (int i = 0; i < qd; i++) begin
            put_name($urandom_range(0, 3), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 15) == 0);
            put16(16'($urandom)); put16(16'($urandom));
        end
        for (int i = 0; i < an + ns + ar; i++) begin
            put_name($urandom_range(0, 2), $urandom_range(0, 2) == 0,
                     $urandom_range(0, 15) == 0);
            put16(16'($urandom)); put16(16'($urandom));
            put16(16'($urandom)); put16(16'($urandom));
            rl = $urandom_range(0, rd);
            put16(16'(rl));
            for (int j = 0; j < rl; j++) put(8'($urandom));
        end
        for (int i = 0; i < trail; i++) put(8'($urandom));
        while (cut > 0 && gram.size() > 1) begin
            void'(gram.pop_back());
            cut--;
        end
        gram[gram.size()-1].last_byte = 1'b1;
        foreach (gram[i]) byte_q.push_back(gram[i]);
    endtask

    task automatic queue_noise(int n);
        t_in_beat x;
        for (int i = 0; i < n; i++) begin
            x.data_byte = 8'($urandom);
            x.last_byte = (i == n - 1) || ($urandom_range(0, 20) == 0);
            byte_q.push_back(x);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("dns_message_field_parser_tb failed");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            gap_left    <= 0;
            burst_left  <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                parsed_q.push_back(parse_byte(in_ch.data));
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    in_ch.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (byte_q.size() > 0 && !hold_send) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= byte_q.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_phase  <= 0;
        end else begin
            stall_phase  <= (stall_phase + 1) % 97;
            out_ch.ready <= stall_phase < 30 ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (out_ch.valid && out_ch.ready) begin
                if (parsed_q.size() == 0) begin
                    $error("unexpected beat");
                    n_fail++;
                end else begin
                    t_out_beat e;
                    e = parsed_q.pop_front();
                    if (e.section != out_ch.data.section) begin
                        $error("section exp %0d got %0d", e.section, out_ch.data.section);
                        n_fail++;
                    end
                    if (e.field_kind != out_ch.data.field_kind) begin
                        $error("field_kind exp %0d got %0d", e.field_kind,
                               out_ch.data.field_kind);
                        n_fail++;
                    end
                    if (e.record_index != out_ch.data.record_index) begin
                        $error("record_index exp %0d got %0d", e.record_index,
                               out_ch.data.record_index);
                        n_fail++;
                    end
                    if (e.field_done != out_ch.data.field_done) begin
                        $error("field_done exp %0d got %0d", e.field_done,
                               out_ch.data.field_done);
                        n_fail++;
                    end
                    if (e.field_value != out_ch.data.field_value) begin
                        $error("field_value exp %h got %h", e.field_value,
                               out_ch.data.field_value);
                        n_fail++;
                    end
                    if (e.status != out_ch.data.status) begin
                        $error("status exp %0d got %0d", e.status, out_ch.data.status);
                        n_fail++;
                    end
                    if (e.message_done != out_ch.data.message_done) begin
                        $error("message_done exp %0d got %0d", e.message_done,
                               out_ch.data.message_done);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial begin
        n_fail = 0;
        hold_send = 1'b0;
        parse_reset();
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, one question, a record per section, cut, bad names
        build_gram(0, 0, 0, 0, 0, 0, 0);
        build_gram(1, 0, 0, 0, 0, 0, 0);
        build_gram(0, 1, 1, 1, 0, 2, 0);
        build_gram(1, 1, 0, 0, 6, 0, 5);
        gram.delete();
        put16(16'hffff); put16(16'h0000); put16(16'd1); put16(16'd0);
        put16(16'd0); put16(16'd0);
        put(8'h80);
        put16(16'hffff); put16(16'h0000);
        gram[gram.size()-1].last_byte = 1'b1;
        foreach (gram[i]) byte_q.push_back(gram[i]);
        gram.delete();
        put16(16'd0); put16(16'd0); put16(16'd1); put16(16'd0);
        put16(16'd0); put16(16'd0);
        put_long_name();
        put16(16'd1); put16(16'd1);
        gram[gram.size()-1].last_byte = 1'b1;
        foreach (gram[i]) byte_q.push_back(gram[i]);

        // pause until all results are in
        wait (byte_q.size() == 0 && !in_ch.valid);
        wait (parsed_q.size() == 0);
        hold_send = 1'b1;
        repeat (4) @(posedge i_clk);
        hold_send = 1'b0;

        // random datagrams: noise, trailing bytes, truncated or well formed
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0: queue_noise($urandom_range(1, 20));
                1: build_gram($urandom_range(0, 2), $urandom_range(0, 2), 0,
                              $urandom_range(0, 1), 8, $urandom_range(1, 3), 0);
                2: build_gram($urandom_range(0, 2), $urandom_range(0, 2),
                              $urandom_range(0, 1), 0, 8, 0, $urandom_range(1, 10));
                default: build_gram($urandom_range(0, 2), $urandom_range(0, 2),
                                    $urandom_range(0, 1), $urandom_range(0, 1), 8, 0, 0);
            endcase
        end

        wait (byte_q.size() == 0 && !in_ch.valid);
        wait (parsed_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0 && parsed_q.size() == 0)
            $display("dns_message_field_parser_tb passed");
        else
            $display("dns_message_field_parser_tb failed");
        $finish;
    end
endmodule
